// ----- design/sndi_pkg.sv -----
// Shared types, constants and helpers for the soft-nibble convolutional deinterleaver.
// No dependencies; imported by every module of the block.
package sndi_pkg;

  localparam int unsigned LANES   = 8;
  localparam int unsigned NIB_W   = 4;
  localparam int unsigned SOFT_W  = 5;
  localparam int unsigned WORD_W  = LANES * NIB_W;
  localparam int unsigned OUT_W   = LANES * SOFT_W;
  localparam int unsigned PHASE_W = $clog2(LANES);

  // Fill count at which the pipe is primed and every beat yields a result
  localparam logic [PHASE_W-1:0] FILL_FULL = PHASE_W'(LANES - 1);

  typedef logic [WORD_W-1:0]  acc_t;
  typedef logic [PHASE_W-1:0] phase_t;
  typedef logic [OUT_W-1:0]   soft_vec_t;

  // Per-beat control broadcast to every accumulator lane
  typedef struct packed {
    logic   upd;
    logic   restart;
    phase_t phase;
  } lane_ctl_t;

  // Sign-extended nibble v mapped to 2v+1, kept to five bits
  function automatic logic [SOFT_W-1:0] soft_of_nibble(input logic [NIB_W-1:0] nib);
    soft_of_nibble = {nib, 1'b1};
  endfunction

endpackage

// ----- design/sndi_lane.sv -----
// One accumulator lane: holds a 32-bit accumulator and overwrites one nibble per beat.
// Depends on sndi_pkg.
module sndi_lane import sndi_pkg::*; #(
  parameter int unsigned LANE_IDX = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  lane_ctl_t ctl,
  input  acc_t      word,
  output acc_t      acc
);

  localparam phase_t IDX = PHASE_W'(LANE_IDX);

  acc_t   acc_r;
  acc_t   acc_nxt;
  phase_t pos;

  // Nibble position this accumulator takes on the current beat
  assign pos = ctl.phase - IDX;

  // Replace the selected nibble; restart starts from a cleared accumulator
  always_comb begin
    acc_nxt = ctl.restart ? '0 : acc_r;
    for (int k = 0; k < LANES; k++) begin
      if (pos == PHASE_W'(k)) begin
        acc_nxt[k*NIB_W +: NIB_W] = word[k*NIB_W +: NIB_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (ctl.upd) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

// ----- design/sndi_merge.sv -----
// Merge stage: picks the finished accumulator, maps nibbles to soft values, output register.
// Depends on sndi_pkg.
module sndi_merge import sndi_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  acc_t       accs [LANES],
  input  phase_t     sel,
  input  logic [NIB_W-1:0] top_nib,
  input  logic       load,
  input  logic       out_tready,
  output logic       out_tvalid,
  output soft_vec_t  out_tdata,
  output logic       slot_free
);

  logic      out_valid_r;
  logic      out_valid_nxt;
  soft_vec_t out_data_r;
  soft_vec_t soft_nxt;
  acc_t      picked;

  // Selected accumulator as it stands after this beat: top nibble comes from the word
  always_comb begin
    picked = accs[sel];
    picked[WORD_W-1 -: NIB_W] = top_nib;
    for (int k = 0; k < LANES; k++) begin
      soft_nxt[k*SOFT_W +: SOFT_W] = soft_of_nibble(picked[(LANES-1-k)*NIB_W +: NIB_W]);
    end
  end

  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Output beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= soft_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- design/soft_nibble_convolutional_deinterleaver.sv -----
// Soft-nibble convolutional deinterleaver, 8 lanes by 8 slots.
// A result appears on the output in the cycle after the beat that completes it.
// Throughput: one input beat per cycle while the output is not stalled; all eight accumulator
// lanes update in parallel and the merge stage's single output register sets the pace.
// Reset (synchronous, rst_n low) clears phase, fill count, accumulators and output valid;
// the first seven beats after reset or restart produce no result.
module soft_nibble_convolutional_deinterleaver import sndi_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [WORD_W-1:0] in_tdata,   // soft_word[31:0]
  input  logic              in_tuser,   // restart
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata   // soft_0[4:0], soft_1 .. soft_7[39:35]
);

  logic      accept;
  logic      emit;
  logic      slot_free;
  phase_t    phase_r;
  phase_t    phase_nxt;
  phase_t    fill_r;
  phase_t    fill_nxt;
  phase_t    phase_eff;
  phase_t    fill_eff;
  lane_ctl_t ctl;
  acc_t      accs [LANES];

  assign in_tready = slot_free;
  assign accept    = in_tvalid && in_tready;

  // Restart clears the counters ahead of this beat
  assign phase_eff = in_tuser ? '0 : phase_r;
  assign fill_eff  = in_tuser ? '0 : fill_r;
  assign emit      = (fill_eff == FILL_FULL);

  assign phase_nxt = phase_eff + PHASE_W'(1);
  assign fill_nxt  = (fill_eff == FILL_FULL) ? FILL_FULL : fill_eff + PHASE_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      fill_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      fill_r  <= fill_nxt;
    end
  end

  assign ctl.upd     = accept;
  assign ctl.restart = in_tuser;
  assign ctl.phase   = phase_eff;

  // Accumulator lanes
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    sndi_lane #(.LANE_IDX(g)) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .word  (in_tdata),
      .acc   (accs[g])
    );
  end

  // Accumulator finished by this beat sits one phase ahead
  sndi_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .accs       (accs),
    .sel        (phase_nxt),
    .top_nib    (in_tdata[WORD_W-1 -: NIB_W]),
    .load       (accept && emit),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .slot_free  (slot_free)
  );

endmodule

// ----- design/sndi_checker.sv -----
// Port-level checks for the soft-nibble deinterleaver, bound to the top level.
// Depends on sndi_pkg.
module sndi_checker import sndi_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              in_tuser,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_W-1:0]  out_tdata
);

  // A stalled output beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat changed while stalled");

  // Every soft value is odd
  a_odd: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] && out_tdata[5] && out_tdata[10] && out_tdata[15] &&
                    out_tdata[20] && out_tdata[25] && out_tdata[30] && out_tdata[35]))
    else $error("soft value is even");

  // A new output beat only follows an accepted input beat
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready))
    else $error("output beat without input beat");

  // A restart beat produces no result
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !out_tvalid || $past(out_tvalid && !out_tready))
    else $error("restart beat produced a result");

  // Input is taken whenever the output register is empty
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

endmodule

bind soft_nibble_convolutional_deinterleaver sndi_checker u_sndi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
